// ===== hw/rtl/ssa_pkg.sv =====
// ssa_pkg: shared types and codes for the swap slot allocator
// used by ssa_ffz and swap_slot_allocator_core; depends on nothing
`timescale 1ns / 1ps

package ssa_pkg;

   // bitmap word geometry
   localparam int WORD_W = 32;
   localparam int BIT_W  = 5;

   // request operation codes
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_NOT_USED = 2'd2;
   localparam logic [1:0] STATUS_RANGE    = 2'd3;

   // outcome of a lowest-free-bit search over one bitmap word
   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } find_type;

endpackage

// ===== hw/rtl/ssa_ram.sv =====
// ssa_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module ssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/ssa_ffz.sv =====
// ssa_ffz: lowest free bit below a limit within one bitmap word
// depends on ssa_pkg
`timescale 1ns / 1ps

module ssa_ffz (
   input  logic [ssa_pkg::WORD_W-1:0] word,
   input  logic [ssa_pkg::BIT_W:0]    lim,
   output ssa_pkg::find_type          res
);

   // priority search, lowest candidate wins
   always_comb begin
      res.found   = 1'b0;
      res.bit_idx = '0;
      for (int b = ssa_pkg::WORD_W - 1; b >= 0; b--) begin
         if (!word[b] && ((ssa_pkg::BIT_W + 1)'(b) < lim)) begin
            res.found   = 1'b1;
            res.bit_idx = ssa_pkg::BIT_W'(b);
         end
      end
   end

endmodule

// ===== hw/rtl/swap_slot_allocator_core.sv =====
// swap_slot_allocator_core: first-fit swap slot allocator over a used-bitmap memory
// depends on ssa_pkg, ssa_ram, ssa_ffz
//
//   channel | direction | handshake            | payload
//   req     | in        | req_tvalid/tready    | tuser operation, tdata slot_index
//   rsp     | out       | rsp_tvalid/tready    | tdata slot_number+sector_address,
//           |           |                      | tuser status, tlast last
//   csr     | in        | csr_valid/csr_ready  | csr_data slot_count
//
// One request at a time. Allocate: accept, read 32-slot bitmap words in turn
// until a free bit turns up (up to ceil(count/32) words), multiply, then
// SECTORS_PER_SLOT results. Read-in: accept, bitmap read, multiply, then the run.
// Free and not-in-use results pass through CHECK to EMIT, out-of-range and
// zero-count allocate results go straight to EMIT; a full scan goes to EMIT from
// its last word. Each result waits while the result register is held by rsp_tready.
// After reset a clearing pass writes every bitmap word with req_tready low. The
// result register lets the next request in while the final result of the previous
// one waits on rsp_tready.
`timescale 1ns / 1ps

module swap_slot_allocator_core #(
   parameter int MAX_SLOTS        = 1024,
   parameter int SECTORS_PER_SLOT = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] slot_index, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] operation
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] slot_number, [22:10] sector_address, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast,
   // slot count register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [10:0] csr_data
);

   localparam int WORDS = (MAX_SLOTS + ssa_pkg::WORD_W - 1) / ssa_pkg::WORD_W;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SW    = $clog2(MAX_SLOTS);
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int OFF_W = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;
   localparam logic [AW-1:0]    LAST_WORD = AW'(WORDS - 1);
   localparam logic [OFF_W-1:0] LAST_OFF  = OFF_W'(SECTORS_PER_SLOT - 1);

   // state codes
   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_MULT  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]                  state_ff, state_in;
   logic [10:0]                 count_ff;
   logic [AW-1:0]               wrd_ff, wrd_in;
   logic [1:0]                  op_ff, op_in;
   logic [9:0]                  idx_ff, idx_in;
   logic [SW-1:0]               slot_ff, slot_in;
   logic [9:0]                  num_ff, num_in;
   logic [12:0]                 sec_ff, sec_in;
   logic [1:0]                  stat_ff, stat_in;
   logic                        single_ff, single_in;
   logic [OFF_W-1:0]            off_ff, off_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [9:0]                  rsp_num_ff, rsp_num_in;
   logic [12:0]                 rsp_sec_ff, rsp_sec_in;
   logic [1:0]                  rsp_stat_ff, rsp_stat_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   logic [ssa_pkg::WORD_W-1:0]  wr_data;
   logic [AW-1:0]               rd_addr;
   logic [ssa_pkg::WORD_W-1:0]  rd_data;

   logic [CNT_W-1:0]            eff_cnt;
   logic [31:0]                 word_base;
   logic [31:0]                 remain;
   logic [ssa_pkg::BIT_W:0]     lim;
   ssa_pkg::find_type           fz;
   logic                        req_fire;
   logic                        out_free;
   logic                        run_last;
   logic [ssa_pkg::BIT_W-1:0]   idx_bit;

   // bitmap memory
   ssa_ram #(
      .WIDTH (ssa_pkg::WORD_W),
      .DEPTH (WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // free-bit search on the word just read
   ssa_ffz u_ffz (
      .word (rd_data),
      .lim  (lim),
      .res  (fz)
   );

   // effective slot count, saturated to the map size
   always_comb begin
      if (32'(count_ff) > 32'(MAX_SLOTS)) begin
         eff_cnt = CNT_W'(MAX_SLOTS);
      end else begin
         eff_cnt = CNT_W'(count_ff);
      end
   end

   // usable bits in the current scan word
   assign word_base = 32'(wrd_ff) << ssa_pkg::BIT_W;
   assign remain    = 32'(eff_cnt) - word_base;
   assign lim       = (remain >= 32'(ssa_pkg::WORD_W)) ?
                      (ssa_pkg::BIT_W + 1)'(ssa_pkg::WORD_W) : remain[ssa_pkg::BIT_W:0];

   assign idx_bit    = idx_ff[ssa_pkg::BIT_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign run_last   = single_ff || (off_ff == LAST_OFF);
   assign csr_ready  = 1'b1;

   // control and memory sequencing
   always_comb begin
      state_in     = state_ff;
      wrd_in       = wrd_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      num_in       = num_ff;
      sec_in       = sec_ff;
      stat_in      = stat_ff;
      single_in    = single_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_num_in   = rsp_num_ff;
      rsp_sec_in   = rsp_sec_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = wrd_ff;
      wr_data      = '0;
      rd_addr      = wrd_ff;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            wrd_in = wrd_ff + AW'(1);
            if (wrd_ff == LAST_WORD) begin
               wrd_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_tuser;
               idx_in    = req_tdata[9:0];
               slot_in   = SW'(32'(req_tdata[9:0]));
               num_in    = req_tdata[9:0];
               sec_in    = '0;
               single_in = 1'b1;
               if (req_tuser == ssa_pkg::OP_ALLOC) begin
                  if (eff_cnt == '0) begin
                     num_in   = '0;
                     stat_in  = ssa_pkg::STATUS_FULL;
                     state_in = S_EMIT;
                  end else begin
                     wrd_in   = '0;
                     rd_addr  = '0;
                     state_in = S_SCAN;
                  end
               end else if (req_tuser == ssa_pkg::OP_READ ||
                            req_tuser == ssa_pkg::OP_FREE) begin
                  if (32'(req_tdata[9:0]) >= 32'(eff_cnt)) begin
                     stat_in  = ssa_pkg::STATUS_RANGE;
                     state_in = S_EMIT;
                  end else begin
                     wrd_in   = AW'(32'(req_tdata[9:0]) >> ssa_pkg::BIT_W);
                     rd_addr  = AW'(32'(req_tdata[9:0]) >> ssa_pkg::BIT_W);
                     state_in = S_CHECK;
                  end
               end
            end
         end
         S_SCAN: begin
            if (fz.found) begin
               wr_en    = 1'b1;
               wr_data  = rd_data | (ssa_pkg::WORD_W'(1) << fz.bit_idx);
               slot_in  = SW'(word_base | 32'(fz.bit_idx));
               num_in   = 10'(word_base | 32'(fz.bit_idx));
               state_in = S_MULT;
            end else if (word_base + 32'(ssa_pkg::WORD_W) >= 32'(eff_cnt)) begin
               num_in   = '0;
               stat_in  = ssa_pkg::STATUS_FULL;
               state_in = S_EMIT;
            end else begin
               wrd_in  = wrd_ff + AW'(1);
               rd_addr = wrd_ff + AW'(1);
            end
         end
         S_CHECK: begin
            wr_data = rd_data & ~(ssa_pkg::WORD_W'(1) << idx_bit);
            if (op_ff == ssa_pkg::OP_READ) begin
               if (!rd_data[idx_bit]) begin
                  stat_in  = ssa_pkg::STATUS_NOT_USED;
                  state_in = S_EMIT;
               end else begin
                  wr_en    = 1'b1;
                  state_in = S_MULT;
               end
            end else begin
               wr_en    = 1'b1;
               stat_in  = ssa_pkg::STATUS_OK;
               state_in = S_EMIT;
            end
         end
         S_MULT: begin
            sec_in    = 13'(32'(slot_ff) * 32'(SECTORS_PER_SLOT));
            stat_in   = ssa_pkg::STATUS_OK;
            single_in = 1'b0;
            off_in    = '0;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = num_ff;
               rsp_sec_in   = sec_ff;
               rsp_stat_in  = stat_ff;
               rsp_last_in  = run_last;
               sec_in       = sec_ff + 13'd1;
               off_in       = off_ff + OFF_W'(1);
               if (run_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         wrd_ff       <= '0;
         count_ff     <= 11'd1024;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wrd_ff       <= wrd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      slot_ff     <= slot_in;
      num_ff      <= num_in;
      sec_ff      <= sec_in;
      stat_ff     <= stat_in;
      single_ff   <= single_in;
      off_ff      <= off_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_sec_ff  <= rsp_sec_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_last_ff <= rsp_last_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_sec_ff, rsp_num_ff};
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
